// File: hw/rtl/lfh_pkg.sv
// Shared types, register indexes and reset values of the level follower.
package lfh_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned AIR_W      = 24;
  localparam int unsigned DEV_W      = 16;
  localparam int unsigned SAT_W      = 23;
  localparam int unsigned LOST_W     = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AIR_CAP    = 3'd0,
    REG_WATER_OFS  = 3'd1,
    REG_HYST_WIDTH = 3'd2,
    REG_SAT_LIMIT  = 3'd3,
    REG_BIG_DEV    = 3'd4,
    REG_MED_DEV    = 3'd5,
    REG_LOST_LIMIT = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ACT_HOLD = 2'd0,
    ACT_UP   = 2'd1,
    ACT_DOWN = 2'd2
  } move_act_t;

  typedef enum logic [1:0] {
    STEP_SMALL  = 2'd0,
    STEP_MEDIUM = 2'd1,
    STEP_BIG    = 2'd2
  } step_sz_t;

  localparam logic signed [AIR_W-1:0] AIR_CAP_RST    = 24'sd0;
  localparam logic [DEV_W-1:0]        WATER_OFS_RST  = 16'd500;
  localparam logic [DEV_W-1:0]        HYST_WIDTH_RST = 16'd50;
  localparam logic [SAT_W-1:0]        SAT_LIMIT_RST  = 23'd99990;
  localparam logic [DEV_W-1:0]        BIG_DEV_RST    = 16'd800;
  localparam logic [DEV_W-1:0]        MED_DEV_RST    = 16'd300;
  localparam logic [LOST_W-1:0]       LOST_LIMIT_RST = 8'd20;
  localparam logic [LOST_W-1:0]       LOST_MAX       = 8'd255;

endpackage

// File: hw/rtl/level_follow_hysteresis_stepper_core.sv
// Level follower: per-sample hold/up/down decision with step size and lost counter.
//
// Usage:
//   in_*   : one signed capacitance sample per transfer (valid/ready).
//   out_*  : one result per sample (move action, step size, saturation flag,
//            relearn request, lost counter after the sample).
//   cfg_*  : register write port (cfg_we, cfg_index, cfg_data), no wait states.
//            Write registers only while no sample is in flight.
// Path: a sample accepted on in_* is held in the input register, then its result is
//   held in the result register, which drives out_*.
// Throughput: one sample per cycle while out_ready is high; the lost counter update
//   closes in the single compare/step stage, so back-to-back samples see each other's count.
// Reset: synchronous, active low; registers return to their defaults, the
//   lost counter clears and both stages empty.
// Stall: while out_ready is low the result holds; the input register keeps one
//   more sample, and in_ready drops only when both stages are full.
module level_follow_hysteresis_stepper_core #(
  parameter int unsigned SAMPLE_WIDTH = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lfh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lfh_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_capacitance,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_move_action,
  output logic [1:0]                        out_step_size,
  output logic                              out_saturated,
  output logic                              out_relearn_request,
  output logic [lfh_pkg::LOST_W-1:0]        out_lost_level
);
  import lfh_pkg::*;

  // compare width: holds sample, thresholds and their differences
  localparam int unsigned CW = ((SAMPLE_WIDTH > 26) ? SAMPLE_WIDTH : 26) + 2;

  // configuration registers
  logic signed [AIR_W-1:0] air_cap_r;
  logic [DEV_W-1:0]        water_ofs_r;
  logic [DEV_W-1:0]        hyst_width_r;
  logic [SAT_W-1:0]        sat_limit_r;
  logic [DEV_W-1:0]        big_dev_r;
  logic [DEV_W-1:0]        med_dev_r;
  logic [LOST_W-1:0]       lost_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      air_cap_r    <= AIR_CAP_RST;
      water_ofs_r  <= WATER_OFS_RST;
      hyst_width_r <= HYST_WIDTH_RST;
      sat_limit_r  <= SAT_LIMIT_RST;
      big_dev_r    <= BIG_DEV_RST;
      med_dev_r    <= MED_DEV_RST;
      lost_limit_r <= LOST_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AIR_CAP:    air_cap_r    <= $signed(cfg_data[AIR_W-1:0]);
        REG_WATER_OFS:  water_ofs_r  <= cfg_data[DEV_W-1:0];
        REG_HYST_WIDTH: hyst_width_r <= cfg_data[DEV_W-1:0];
        REG_SAT_LIMIT:  sat_limit_r  <= cfg_data[SAT_W-1:0];
        REG_BIG_DEV:    big_dev_r    <= cfg_data[DEV_W-1:0];
        REG_MED_DEV:    med_dev_r    <= cfg_data[DEV_W-1:0];
        REG_LOST_LIMIT: lost_limit_r <= cfg_data[LOST_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic                           s1_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] cap_r;
  logic                           out_valid_r;
  logic                           s1_adv;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cap_r <= in_capacitance;
    end
  end

  // decision logic
  logic signed [CW-1:0] cap_x, upper_x, lower_x, sat_x, big_x, med_x, dev;
  logic                 is_sat, is_up, is_down;
  logic [LOST_W-1:0]    lost_r, lost_mid, lost_nxt;
  move_act_t            act_nxt;
  step_sz_t             step_nxt;
  logic                 relearn_nxt;

  always_comb begin
    cap_x   = CW'(cap_r);
    upper_x = CW'(air_cap_r) + CW'({1'b0, water_ofs_r});
    lower_x = upper_x - CW'({1'b0, hyst_width_r});
    sat_x   = CW'({1'b0, sat_limit_r});
    big_x   = CW'({1'b0, big_dev_r});
    med_x   = CW'({1'b0, med_dev_r});

    is_sat  = cap_x > sat_x;
    is_up   = cap_x >= upper_x;
    is_down = cap_x <= lower_x;
    dev     = is_up ? (cap_x - upper_x) : (lower_x - cap_x);

    act_nxt     = ACT_HOLD;
    step_nxt    = STEP_SMALL;
    lost_mid    = '0;
    relearn_nxt = 1'b0;

    priority if (is_sat) begin
      act_nxt  = ACT_UP;
      step_nxt = STEP_BIG;
      lost_mid = (lost_r == LOST_MAX) ? lost_r : lost_r + 1'b1;
    end else if (is_up || is_down) begin
      act_nxt = is_up ? ACT_UP : ACT_DOWN;
      priority if (dev > big_x) step_nxt = STEP_BIG;
      else if (dev > med_x)     step_nxt = STEP_MEDIUM;
      else                      step_nxt = STEP_SMALL;
      if (dev >= big_x) begin
        lost_mid = (lost_r == LOST_MAX) ? lost_r : lost_r + 1'b1;
      end else begin
        lost_mid = (lost_r == '0) ? lost_r : lost_r - 1'b1;
      end
    end else begin
      lost_mid = '0;  // in band: clear, no relearn check
    end

    lost_nxt = lost_mid;
    if ((is_sat || is_up || is_down) && (lost_mid >= lost_limit_r)) begin
      relearn_nxt = 1'b1;
      lost_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lost_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        lost_r <= lost_nxt;
      end
      if (!out_valid_r || out_ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  logic [1:0]        act_r, step_r;
  logic              sat_r, relearn_r;
  logic [LOST_W-1:0] level_r;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      act_r     <= act_nxt;
      step_r    <= step_nxt;
      sat_r     <= is_sat;
      relearn_r <= relearn_nxt;
      level_r   <= lost_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_move_action     = act_r;
  assign out_step_size       = step_r;
  assign out_saturated       = sat_r;
  assign out_relearn_request = relearn_r;
  assign out_lost_level      = level_r;

endmodule

// File: tb/sv/level_follow_hysteresis_stepper_core_tb.sv
// Self-checking testbench for the level follower core: predicts every move decision.
module level_follow_hysteresis_stepper_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lfh_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    move_act_t   action;
    step_sz_t    step;
    logic        saturated;
    logic        relearn;
    logic [7:0]  lost;
  } move_result_t;

  // Mirrors the registers and the lost counter; queues one decision per sample.
  class move_checker;
    logic signed [AIR_W-1:0] air;
    logic [DEV_W-1:0]        water_ofs;
    logic [DEV_W-1:0]        hyst;
    logic [SAT_W-1:0]        sat_lim;
    logic [DEV_W-1:0]        big_dev;
    logic [DEV_W-1:0]        med_dev;
    logic [LOST_W-1:0]       lost_lim;
    logic [LOST_W-1:0]       lost_cnt;
    move_result_t            expected_moves[$];
    int                      errors;

    function new();
      air       = AIR_CAP_RST;
      water_ofs = WATER_OFS_RST;
      hyst      = HYST_WIDTH_RST;
      sat_lim   = SAT_LIMIT_RST;
      big_dev   = BIG_DEV_RST;
      med_dev   = MED_DEV_RST;
      lost_lim  = LOST_LIMIT_RST;
      lost_cnt  = '0;
      errors    = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_AIR_CAP:    air = d;
        REG_WATER_OFS:  water_ofs = d[DEV_W-1:0];
        REG_HYST_WIDTH: hyst = d[DEV_W-1:0];
        REG_SAT_LIMIT:  sat_lim = d[SAT_W-1:0];
        REG_BIG_DEV:    big_dev = d[DEV_W-1:0];
        REG_MED_DEV:    med_dev = d[DEV_W-1:0];
        REG_LOST_LIMIT: lost_lim = d[LOST_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_moves.size();
    endfunction

    function void note_sample(logic signed [23:0] cap);
      longint       c;
      longint       up;
      longint       lo;
      longint       dev;
      move_result_t r;
      c  = cap;
      up = longint'(air) + longint'(water_ofs);
      lo = up - longint'(hyst);
      r  = '0;
      if (c > longint'(sat_lim)) begin
        r.saturated = 1'b1;
        r.action    = ACT_UP;
        r.step      = STEP_BIG;
        if (lost_cnt != LOST_MAX) lost_cnt = lost_cnt + 8'd1;
      end else if (c < up && c > lo) begin
        // inside the band: hold, counter clears, no relearn check
        lost_cnt = '0;
        expected_moves.push_back(r);
        return;
      end else begin
        if (c >= up) begin
          r.action = ACT_UP;
          dev = c - up;
        end else begin
          r.action = ACT_DOWN;
          dev = lo - c;
        end
        if (dev > longint'(big_dev)) r.step = STEP_BIG;
        else if (dev > longint'(med_dev)) r.step = STEP_MEDIUM;
        else r.step = STEP_SMALL;
        if (dev >= longint'(big_dev)) begin
          if (lost_cnt != LOST_MAX) lost_cnt = lost_cnt + 8'd1;
        end else if (lost_cnt != 0) begin
          lost_cnt = lost_cnt - 8'd1;
        end
      end
      if (lost_cnt >= lost_lim) begin
        r.relearn = 1'b1;
        lost_cnt  = '0;
      end
      r.lost = lost_cnt;
      expected_moves.push_back(r);
    endfunction

    function void compare_field(string what, logic [7:0] exp_v, logic [7:0] got_v);
      if (got_v !== exp_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, got_v);
      end
    endfunction

    function void check_move(logic [1:0] act, logic [1:0] step, logic sat, logic rl,
                             logic [7:0] lost);
      move_result_t e;
      if (expected_moves.size() == 0) begin
        errors++;
        $display("%0t: result with no sample outstanding, expected none, actual %0d/%0d/%0d",
                 $time, act, step, lost);
        return;
      end
      e = expected_moves.pop_front();
      compare_field("move_action", e.action, act);
      compare_field("step_size", e.step, step);
      compare_field("saturated", e.saturated, sat);
      compare_field("relearn_request", e.relearn, rl);
      compare_field("lost_level", e.lost, lost);
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  cfg_reg_t                 cfg_index = REG_AIR_CAP;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [23:0]       in_capacitance = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [1:0]               out_move_action;
  logic [1:0]               out_step_size;
  logic                     out_saturated;
  logic                     out_relearn_request;
  logic [LOST_W-1:0]        out_lost_level;

  move_checker sb;
  bit          steady = 1'b0;
  bit          rx_blocked = 1'b0;
  event        hold_off_ev;
  int          cycle_count = 0;

  level_follow_hysteresis_stepper_core #(.SAMPLE_WIDTH(24)) DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_capacitance      (in_capacitance),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_move_action     (out_move_action),
    .out_step_size       (out_step_size),
    .out_saturated       (out_saturated),
    .out_relearn_request (out_relearn_request),
    .out_lost_level      (out_lost_level)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // transfer monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_sample(in_capacitance);
      if (out_valid && out_ready)
        sb.check_move(out_move_action, out_step_size, out_saturated,
                      out_relearn_request, out_lost_level);
    end
  end

  always @(negedge clk) begin
    if (rx_blocked) out_ready <= 1'b0;
    else if (steady) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 99) >= 17);
  end

  // long receiver hold-off, so both pipeline stages fill and in_ready drops
  always begin
    @(hold_off_ev);
    rx_blocked = 1'b1;
    repeat (60) @(posedge clk);
    rx_blocked = 1'b0;
  end

  task automatic send_sample(logic signed [23:0] cap);
    @(negedge clk);
    if (!steady && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_capacitance <= cap;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic stop_samples();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained(int extra);
    while (sb.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic program_reg(cfg_reg_t idx, longint val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    sb.write_reg(idx, val[CFG_DATA_W-1:0]);
  endtask

  task automatic program_all(longint air, longint ofs, longint hy, longint sat,
                             longint big, longint med, longint lim);
    program_reg(REG_AIR_CAP, air);
    program_reg(REG_WATER_OFS, ofs);
    program_reg(REG_HYST_WIDTH, hy);
    program_reg(REG_SAT_LIMIT, sat);
    program_reg(REG_BIG_DEV, big);
    program_reg(REG_MED_DEV, med);
    program_reg(REG_LOST_LIMIT, lim);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic longint pick_range(longint lo, longint hi, longint typ_lo, longint typ_hi);
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return typ_lo + longint'($urandom_range(0, int'(typ_hi - typ_lo)));
  endfunction

  // Samples clustered on the thresholds, the step bounds and the saturation limit.
  function automatic logic signed [23:0] pick_sample(int big_bias);
    longint             up;
    longint             lo;
    longint             v;
    longint             dev;
    logic signed [23:0] raw;
    up  = longint'(sb.air) + longint'(sb.water_ofs);
    lo  = up - longint'(sb.hyst);
    raw = 24'($urandom);
    if ($urandom_range(0, 99) < big_bias) begin
      dev = longint'(sb.big_dev) + longint'($urandom_range(0, 3));
      if ($urandom_range(0, 9) == 0) dev += longint'($urandom_range(0, 100000));
      v = $urandom_range(0, 1) ? up + dev : lo - dev;
    end else begin
      case ($urandom_range(0, 2))
        0:       dev = 0;
        1:       dev = longint'(sb.med_dev);
        default: dev = longint'(sb.big_dev);
      endcase
      dev += longint'($urandom_range(0, 2)) - 1;
      case ($urandom_range(0, 5))
        0:       v = raw;
        1:       v = up + dev;
        2:       v = lo - dev;
        3:       v = lo + longint'($urandom_range(0, sb.hyst));
        4:       v = longint'(sb.sat_lim) + longint'($urandom_range(0, 4)) - 2;
        default: v = up + longint'($urandom_range(0, 6000)) - 3000;
      endcase
    end
    if (v > 64'sd8388607) v = 64'sd8388607;
    if (v < -64'sd8388608) v = -64'sd8388608;
    return v[23:0];
  endfunction

  initial begin
    logic signed [23:0] reset_caps[12];
    logic signed [23:0] low_air_caps[4];
    logic signed [23:0] high_air_caps[4];
    reset_caps    = '{24'sd475, 24'sd500, 24'sd450, 24'sd800, 24'sd801, 24'sd1300,
                      24'sd1301, 24'sd99990, 24'sd99991, 24'sh7FFFFF, 24'sh800000, 24'sd449};
    low_air_caps  = '{24'sh80FFFF, 24'sh80FFFF, 24'sh800000, 24'sh7FFFFF};
    high_air_caps = '{24'sh7FFFFF, 24'sd0, 24'sd1, 24'sh800000};
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // defaults: band, both thresholds, step bounds, saturation edge, field extremes
    foreach (reset_caps[i]) send_sample(reset_caps[i]);
    stop_samples();
    wait_drained(4);

    // lowest air, zero hysteresis (upper side wins), zero step bounds, relearn each move
    program_all(-64'sd8388608, 65535, 0, 8388607, 0, 0, 1);
    foreach (low_air_caps[i]) send_sample(low_air_caps[i]);
    stop_samples();
    wait_drained(4);

    // highest air, zero saturation limit, widest bounds, highest lost limit
    program_all(8388607, 65535, 65535, 0, 65535, 65535, 255);
    foreach (high_air_caps[i]) send_sample(high_air_caps[i]);
    stop_samples();
    wait_drained(4);

    for (int ph = 0; ph < 8; ph++) begin
      program_all(pick_range(-8388608, 8388607, -20000, 20000),
                  pick_range(0, 65535, 0, 3000),
                  pick_range(0, 65535, 0, 500),
                  pick_range(0, 8388607, 0, 60000),
                  pick_range(0, 65535, 0, 3000),
                  pick_range(0, 65535, 0, 1500),
                  pick_range(1, 255, 1, 30));
      steady = (ph == 2);
      for (int i = 0; i < 40; i++) begin
        if (ph == 4 && i == 5) begin
          -> hold_off_ev;
          steady = 1'b1;
        end
        if (ph == 4 && i == 30) steady = 1'b0;
        if (ph == 5 && i == 20) begin
          stop_samples();
          wait_drained(0);
        end
        send_sample(pick_sample(40));
      end
      steady = 1'b0;
      stop_samples();
      wait_drained(4);
    end

    // long run of big deviations so the counter climbs toward the top limit
    program_all(0, 500, 50, 99990, 800, 300, 255);
    for (int i = 0; i < 300; i++) send_sample(pick_sample(95));
    stop_samples();
    wait_drained(8);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
